[hdl/vrpva_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the video register port.
package vrpva_pkg;

    localparam int PATTERN_BYTES_DEF    = 8192;
    localparam int NAME_TABLE_BYTES_DEF = 2048;
    localparam int SPRITE_MEM_BYTES_DEF = 256;

    // Pattern memory and name tables share one video memory, name tables above.
    localparam int VMEM_AW = $clog2(PATTERN_BYTES_DEF + NAME_TABLE_BYTES_DEF);

    localparam logic [1:0] REQ_READ      = 2'd0;
    localparam logic [1:0] REQ_WRITE     = 2'd1;
    localparam logic [1:0] REQ_VBL_ENTER = 2'd2;
    localparam logic [1:0] REQ_VBL_LEAVE = 2'd3;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SPR_A  = 3'd3;
    localparam logic [2:0] REG_SPR_D  = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [VMEM_AW-1:0] addr;
        logic [7:0]         wdata;
    } vmem_cmd_t;

endpackage

[hdl/vrpva_vmem.sv]
`timescale 1ns / 1ps
// Video memory (pattern and name table bytes) with a clearing pass after reset.
module vrpva_vmem #(
    parameter int DEPTH = vrpva_pkg::PATTERN_BYTES_DEF + vrpva_pkg::NAME_TABLE_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vrpva_pkg::vmem_cmd_t cmd,
    output logic [7:0]          rd_data,
    output logic                ready
);
    import vrpva_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic          clearing_reg;
    logic          clearing_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_cnt_reg] <= 8'h00;
        end
        else if (cmd.wr_en)
        begin
            mem[cmd.addr[AW-1:0]] <= cmd.wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data <= mem[cmd.addr[AW-1:0]];
        end
    end

    assign ready = !clearing_reg;

endmodule

[hdl/video_register_port_vram_access.sv]
`timescale 1ns / 1ps
// Top level of the CPU register port with video memory access.
// The block accepts one request per clock cycle unless in_stall is high. On acceptance
// the registers update and the read of the sprite memory or the video memory is issued
// into the second stage; when the second stage advances, the registered memory data goes
// into the data read buffer and the output register.
// After reset the video memory is cleared one byte a cycle, all PATTERN_BYTES +
// NAME_TABLE_BYTES bytes (10240 by default); requests are held off until that pass ends,
// whilst the mirroring register may be written at any time. A full output register with
// stall held high stops the pipeline after one further request.
module video_register_port_vram_access #(
    parameter int PATTERN_BYTES    = vrpva_pkg::PATTERN_BYTES_DEF,
    parameter int NAME_TABLE_BYTES = vrpva_pkg::NAME_TABLE_BYTES_DEF,
    parameter int SPRITE_MEM_BYTES = vrpva_pkg::SPRITE_MEM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [2:0]  reg_index,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        nmi_raise,
    output logic [15:0] current_vram_addr,
    output logic [2:0]  fine_scroll_x
);
    import vrpva_pkg::*;

    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int NT_AW  = $clog2(NAME_TABLE_BYTES);
    localparam int SPR_AW = $clog2(SPRITE_MEM_BYTES);

    localparam logic [1:0] KIND_PLAIN  = 2'd0;
    localparam logic [1:0] KIND_SPRITE = 2'd1;
    localparam logic [1:0] KIND_VDATA  = 2'd2;

    // Architectural registers
    logic        mirror_reg;
    logic [7:0]  control_reg, control_next;
    logic [7:0]  mask_reg, mask_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  spr_addr_reg, spr_addr_next;
    logic        latch_reg, latch_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic [14:0] temp_addr_reg, temp_addr_next;
    logic [15:0] video_addr_reg, video_addr_next;
    logic [7:0]  read_buffer_reg, read_buffer_next;
    logic [7:0]  pal_reg [32];

    // Second stage
    logic        s2_valid_reg, s2_valid_next;
    logic [1:0]  s2_kind_reg, s2_kind_next;
    logic [7:0]  s2_rd_reg, s2_rd_next;
    logic        s2_pal_reg, s2_pal_next;
    logic [7:0]  s2_pal_val_reg;
    logic        s2_nmi_reg, s2_nmi_next;
    logic [15:0] s2_vaddr_reg;
    logic [2:0]  s2_fine_reg;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_rd_reg;
    logic        out_nmi_reg;
    logic [15:0] out_vaddr_reg;
    logic [2:0]  out_fine_reg;

    logic        in_acc;
    logic        s2_adv;
    logic        vmem_ready;
    logic [7:0]  vmem_rd_data;
    vmem_cmd_t   vmem_cmd;

    logic [7:0]        spr_mem [SPRITE_MEM_BYTES];
    logic [7:0]        spr_rd_data;
    logic              spr_rd_en;
    logic              spr_wr_en;
    logic [SPR_AW-1:0] spr_idx;

    logic [13:0]        va;
    logic               va_is_pat;
    logic               va_is_pal;
    logic [11:0]        nt_off;
    logic [10:0]        nt_raw;
    logic [VMEM_AW-1:0] vm_idx;
    logic [4:0]         pal_idx;
    logic [7:0]         pal_val;
    logic               pal_we;
    logic [15:0]        va_step;
    logic [7:0]         s2_new_buf;
    logic [7:0]         rb_cur;
    logic [7:0]         s2_result;

    // Address decode for the data port
    always_comb
    begin
        va        = video_addr_reg[13:0];
        va_is_pat = (va < 14'h2000);
        va_is_pal = (va >= 14'h3F00);
        nt_off    = va[11:0];
        nt_raw    = {(mirror_reg ? nt_off[10] : nt_off[11]), nt_off[9:0]};
        if (va_is_pat)
        begin
            vm_idx = VMEM_AW'(va[PAT_AW-1:0]);
        end
        else
        begin
            vm_idx = VMEM_AW'(PATTERN_BYTES) + VMEM_AW'(nt_raw[NT_AW-1:0]);
        end
        // Entries 0x10, 0x14, 0x18 and 0x1C mirror the backdrop entries below them.
        pal_idx = va[4:0];
        if (pal_idx[4] && (pal_idx[1:0] == 2'b00))
        begin
            pal_idx = {1'b0, va[3:0]};
        end
        pal_val = pal_reg[pal_idx] & (mask_reg[0] ? 8'h30 : 8'h3F);
        va_step = video_addr_reg + (control_reg[2] ? 16'd32 : 16'd1);
    end

    // A pending data read in the second stage owns the freshest buffer value.
    assign s2_new_buf = s2_pal_reg ? s2_pal_val_reg : vmem_rd_data;
    assign rb_cur     = (s2_valid_reg && (s2_kind_reg == KIND_VDATA)) ? s2_new_buf
                                                                      : read_buffer_reg;

    assign s2_adv   = s2_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = !vmem_ready || (s2_valid_reg && !s2_adv);
    assign in_acc   = in_valid && !in_stall;
    assign spr_idx  = spr_addr_reg[SPR_AW-1:0];

    always_comb
    begin
        control_next    = control_reg;
        mask_next       = mask_reg;
        status_next     = status_reg;
        spr_addr_next   = spr_addr_reg;
        latch_next      = latch_reg;
        fine_x_next     = fine_x_reg;
        temp_addr_next  = temp_addr_reg;
        video_addr_next = video_addr_reg;
        s2_kind_next    = KIND_PLAIN;
        s2_rd_next      = 8'h00;
        s2_pal_next     = va_is_pal;
        s2_nmi_next     = 1'b0;
        spr_rd_en       = 1'b0;
        spr_wr_en       = 1'b0;
        pal_we          = 1'b0;
        vmem_cmd.rd_en  = 1'b0;
        vmem_cmd.wr_en  = 1'b0;
        vmem_cmd.addr   = vm_idx;
        vmem_cmd.wdata  = write_data;

        if (in_acc)
        begin
            unique case (req_type)
                REQ_READ:
                begin
                    unique case (reg_index)
                        REG_STATUS:
                        begin
                            s2_rd_next     = {status_reg, rb_cur[4:0]};
                            status_next[2] = 1'b0;
                            latch_next     = 1'b0;
                        end
                        REG_SPR_D:
                        begin
                            s2_kind_next = KIND_SPRITE;
                            spr_rd_en    = 1'b1;
                        end
                        REG_DATA:
                        begin
                            s2_kind_next    = KIND_VDATA;
                            s2_rd_next      = rb_cur;
                            vmem_cmd.rd_en  = !va_is_pal;
                            video_addr_next = va_step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                REQ_WRITE:
                begin
                    unique case (reg_index)
                        REG_CTRL:
                        begin
                            s2_nmi_next = !control_reg[7] && write_data[7] && status_reg[2];
                            control_next = write_data;
                            temp_addr_next[11:10] = write_data[1:0];
                        end
                        REG_MASK:
                        begin
                            mask_next = write_data;
                        end
                        REG_SPR_A:
                        begin
                            spr_addr_next = write_data;
                        end
                        REG_SPR_D:
                        begin
                            spr_wr_en     = 1'b1;
                            spr_addr_next = spr_addr_reg + 8'd1;
                        end
                        REG_SCROLL:
                        begin
                            if (!latch_reg)
                            begin
                                fine_x_next         = write_data[2:0];
                                temp_addr_next[4:0] = write_data[7:3];
                                latch_next          = 1'b1;
                            end
                            else
                            begin
                                temp_addr_next[14:12] = write_data[2:0];
                                temp_addr_next[9:5]   = write_data[7:3];
                                latch_next            = 1'b0;
                            end
                        end
                        REG_ADDR:
                        begin
                            if (!latch_reg)
                            begin
                                temp_addr_next[14]   = 1'b0;
                                temp_addr_next[13:8] = write_data[5:0];
                                latch_next           = 1'b1;
                            end
                            else
                            begin
                                temp_addr_next[7:0] = write_data;
                                video_addr_next     = {1'b0, temp_addr_reg[14:8], write_data};
                                latch_next          = 1'b0;
                            end
                        end
                        REG_DATA:
                        begin
                            vmem_cmd.wr_en  = !va_is_pal;
                            pal_we          = va_is_pal;
                            video_addr_next = va_step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                REQ_VBL_ENTER:
                begin
                    status_next[2] = 1'b1;
                    s2_nmi_next    = control_reg[7];
                end
                REQ_VBL_LEAVE:
                begin
                    status_next = 3'b000;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (s2_kind_reg)
            KIND_SPRITE: s2_result = spr_rd_data;
            KIND_VDATA:  s2_result = s2_pal_reg ? s2_pal_val_reg : s2_rd_reg;
            default:     s2_result = s2_rd_reg;
        endcase
    end

    always_comb
    begin
        read_buffer_next = read_buffer_reg;
        if (s2_adv && (s2_kind_reg == KIND_VDATA))
        begin
            read_buffer_next = s2_new_buf;
        end
        s2_valid_next = in_acc || (s2_valid_reg && !s2_adv);
        out_valid_next = s2_adv || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg      <= 1'b0;
            control_reg     <= '0;
            mask_reg        <= '0;
            status_reg      <= '0;
            spr_addr_reg    <= '0;
            latch_reg       <= 1'b0;
            fine_x_reg      <= '0;
            temp_addr_reg   <= '0;
            video_addr_reg  <= '0;
            read_buffer_reg <= '0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < 32; i++)
            begin
                pal_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                mirror_reg <= cfg_write_data;
            end
            control_reg     <= control_next;
            mask_reg        <= mask_next;
            status_reg      <= status_next;
            spr_addr_reg    <= spr_addr_next;
            latch_reg       <= latch_next;
            fine_x_reg      <= fine_x_next;
            temp_addr_reg   <= temp_addr_next;
            video_addr_reg  <= video_addr_next;
            read_buffer_reg <= read_buffer_next;
            s2_valid_reg    <= s2_valid_next;
            out_valid_reg   <= out_valid_next;
            if (pal_we)
            begin
                pal_reg[pal_idx] <= write_data;
            end
        end
    end

    // Payload registers of the two result stages
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s2_kind_reg    <= s2_kind_next;
            s2_rd_reg      <= s2_rd_next;
            s2_pal_reg     <= s2_pal_next;
            s2_pal_val_reg <= pal_val;
            s2_nmi_reg     <= s2_nmi_next;
            s2_vaddr_reg   <= video_addr_next;
            s2_fine_reg    <= fine_x_next;
        end
        if (s2_adv)
        begin
            out_rd_reg    <= s2_result;
            out_nmi_reg   <= s2_nmi_reg;
            out_vaddr_reg <= s2_vaddr_reg;
            out_fine_reg  <= s2_fine_reg;
        end
    end

    // Sprite memory
    always_ff @(posedge clk)
    begin
        if (spr_wr_en)
        begin
            spr_mem[spr_idx] <= write_data;
        end
        if (spr_rd_en)
        begin
            spr_rd_data <= spr_mem[spr_idx];
        end
    end

    vrpva_vmem #(
        .DEPTH (PATTERN_BYTES + NAME_TABLE_BYTES)
    ) u_vmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (vmem_cmd),
        .rd_data (vmem_rd_data),
        .ready   (vmem_ready)
    );

    assign out_valid         = out_valid_reg;
    assign read_data         = out_rd_reg;
    assign nmi_raise         = out_nmi_reg;
    assign current_vram_addr = out_vaddr_reg;
    assign fine_scroll_x     = out_fine_reg;

    // No request may enter whilst the video memory is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n) !vmem_ready |-> !in_acc)
        else $error("request accepted during video memory clearing");

    // A blocked second stage keeps its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && out_valid_reg && out_stall) |=> s2_valid_reg)
        else $error("second stage request lost while output blocked");

    // Entering vblank sets the vblank flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (req_type == REQ_VBL_ENTER)) |=> status_reg[2])
        else $error("vblank flag not set");

    // A palette data read loads the read buffer with the palette byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_adv && (s2_kind_reg == KIND_VDATA) && s2_pal_reg)
        |=> (read_buffer_reg == $past(s2_pal_val_reg)))
        else $error("read buffer not loaded from palette");

endmodule
